/* rtl/slfb_pkg.sv */
`timescale 1ns / 1ps
// Shared types, field widths and codes for the serpentine LED frame buffer.
// Depends on nothing; used by the divider, the top level and the testbench.
package slfb_pkg;

  // Field widths of the item, result and configuration channels
  localparam int LED_COUNT_W   = 9;
  localparam int ROW_COUNT_W   = 9;
  localparam int OFFSET_W      = 10;
  localparam int LEN_W         = 11;
  localparam int BYTE_W        = 8;
  localparam int IDX_W         = 8;
  localparam int STATUS_W      = 3;
  localparam int PHYS_W        = 8;
  localparam int WORD_W        = 32;
  localparam int CFG_INDEX_W   = 1;
  localparam int CFG_DATA_W    = 9;

  // Panel geometry defaults
  localparam int DEFAULT_MAX_LEDS = 256;
  localparam int BYTES_PER_LED    = 4;
  localparam int LANE_W           = 2;
  localparam int ADDR_SUM_W       = 12;

  // Divider operand width (led_count and row_count are both nine bits)
  localparam int DIV_W = 9;

  // Reset values of the configuration registers
  localparam logic [LED_COUNT_W-1:0] LED_COUNT_RESET = 9'd256;
  localparam logic [ROW_COUNT_W-1:0] ROW_COUNT_RESET = 9'd1;

  // Item kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_LED_COUNT = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ROW_COUNT = 1'b1;

  // Result status codes
  typedef logic [STATUS_W-1:0] status_t;
  localparam status_t STAT_OK           = 3'd0;
  localparam status_t STAT_EMPTY        = 3'd1;
  localparam status_t STAT_TOO_LONG     = 3'd2;
  localparam status_t STAT_NO_FIT       = 3'd3;
  localparam status_t STAT_BAD_GEOMETRY = 3'd4;
  localparam status_t STAT_RANGE        = 3'd5;

  // Sequencer states of the top level
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_GEO,
    S_IDX,
    S_MAP,
    S_FETCH,
    S_STORE,
    S_MERGE,
    S_END,
    S_RESULT
  } state_t;

  // Divider result handed to the sequencer
  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
    logic [DIV_W-1:0] remainder;
  } div_result_t;

endpackage

/* rtl/slfb_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module slfb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/slfb_div.sv */
`timescale 1ns / 1ps
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on slfb_pkg for the operand width and the result struct.
module slfb_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [slfb_pkg::DIV_W-1:0] dividend,
  input  logic [slfb_pkg::DIV_W-1:0] divisor,
  output slfb_pkg::div_result_t     result
);

  localparam int CNT_W = $clog2(slfb_pkg::DIV_W);

  logic                       busy;
  logic                       done;
  logic [CNT_W-1:0]           count;
  logic [slfb_pkg::DIV_W-1:0] quo;
  logic [slfb_pkg::DIV_W-1:0] rem;
  logic [slfb_pkg::DIV_W-1:0] divisor_q;
  logic [slfb_pkg::DIV_W:0]   trial;
  logic                       fits;

  // Shift the next dividend bit into the partial remainder and try a subtract
  assign trial = {rem, quo[slfb_pkg::DIV_W-1]};
  assign fits  = trial >= {1'b0, divisor_q};

  // Control: load on start, iterate once per bit, pulse done at the end
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == CNT_W'(slfb_pkg::DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: quotient bits enter from the right as dividend bits leave
  always_ff @(posedge clk) begin
    if (start) begin
      quo       <= dividend;
      rem       <= '0;
      divisor_q <= divisor;
    end else if (busy) begin
      quo <= {quo[slfb_pkg::DIV_W-2:0], fits};
      if (fits) begin
        rem <= slfb_pkg::DIV_W'(trial - {1'b0, divisor_q});
      end else begin
        rem <= trial[slfb_pkg::DIV_W-1:0];
      end
    end
  end

  assign result.done      = done;
  assign result.quotient  = quo;
  assign result.remainder = rem;

endmodule

/* rtl/serpentine_led_frame_buffer.sv */
`timescale 1ns / 1ps
// Serpentine LED frame buffer: one item at a time, state in a word-wide RAM.
// Read: geometry divide, index divide, map, RAM read (FETCH), then the result.
// Run byte: STORE and END when dropped, plus MERGE (RAM RMW) when stored, and
// a result on the last byte (status); first byte adds the geometry divide.
// Reset: a sweep zeroes all MAX_LEDS words; items stall, config is taken.
module serpentine_led_frame_buffer #(
  parameter int MAX_LEDS = slfb_pkg::DEFAULT_MAX_LEDS
) (
  input  logic                             clk,
  input  logic                             rst,
  // configuration write channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [slfb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [slfb_pkg::CFG_DATA_W-1:0]  cfg_data,
  // item channel
  input  logic                             item_valid,
  output logic                             item_stall,
  input  logic                             kind,
  input  logic [slfb_pkg::OFFSET_W-1:0]    start_offset,
  input  logic [slfb_pkg::LEN_W-1:0]       run_length,
  input  logic [slfb_pkg::BYTE_W-1:0]      data_byte,
  input  logic [slfb_pkg::IDX_W-1:0]       led_index,
  // result channel
  output logic                             result_valid,
  input  logic                             result_stall,
  output logic [slfb_pkg::STATUS_W-1:0]    status,
  output logic [slfb_pkg::PHYS_W-1:0]      physical_index,
  output logic [slfb_pkg::WORD_W-1:0]      pixel_word
);

  localparam int LED_AW   = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
  localparam int DIV_W    = slfb_pkg::DIV_W;
  localparam int SUM_W    = slfb_pkg::ADDR_SUM_W;
  localparam int PROD_W   = 2 * DIV_W;
  localparam int WORD_W   = slfb_pkg::WORD_W;
  localparam int BYTE_W   = slfb_pkg::BYTE_W;
  localparam int LANES    = slfb_pkg::BYTES_PER_LED;
  localparam int LANE_W   = slfb_pkg::LANE_W;

  slfb_pkg::state_t state, state_next;

  // configuration registers
  logic [slfb_pkg::LED_COUNT_W-1:0] led_count;
  logic [slfb_pkg::ROW_COUNT_W-1:0] row_count;

  // latched item
  logic                          item_kind;
  logic [slfb_pkg::OFFSET_W-1:0] item_offset;
  logic [slfb_pkg::LEN_W-1:0]    item_len;
  logic [BYTE_W-1:0]             item_byte;
  logic [slfb_pkg::IDX_W-1:0]    item_idx;

  // run state
  logic [slfb_pkg::LEN_W-1:0]    run_position;
  logic [slfb_pkg::OFFSET_W-1:0] run_base;
  logic                          run_accepted;
  slfb_pkg::status_t             run_status;

  // mapping datapath
  logic [DIV_W-1:0]  cols;
  logic [PROD_W-1:0] prod;
  logic [DIV_W-1:0]  pos;

  // pending result
  slfb_pkg::status_t           pend_status;
  logic [slfb_pkg::PHYS_W-1:0] pend_phys;
  logic [WORD_W-1:0]           pend_word;

  // clearing sweep
  logic [LED_AW-1:0] clr_cnt;

  // divider and RAM hookup
  logic                  div_start;
  logic [DIV_W-1:0]      div_dividend;
  slfb_pkg::div_result_t div_res;
  logic                  ram_we;
  logic [LED_AW-1:0]     ram_waddr;
  logic [WORD_W-1:0]     ram_wdata;
  logic [LED_AW-1:0]     ram_raddr;
  logic [WORD_W-1:0]     ram_rdata;

  // derived control values
  logic                  geo_ok;
  logic                  idx_out;
  logic [slfb_pkg::LEN_W-1:0] frame_bytes;
  slfb_pkg::status_t     chk_status;
  logic [SUM_W-1:0]      byte_addr;
  logic                  store_hit;
  logic [LED_AW-1:0]     word_addr;
  logic [LANE_W-1:0]     lane;
  logic [WORD_W-1:0]     merged;
  logic                  run_last;
  logic                  out_free;

  slfb_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (row_count),
    .result   (div_res)
  );

  slfb_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_LEDS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Geometry and run checks
  assign geo_ok = (row_count != '0) && (int'(led_count) <= MAX_LEDS)
                  && (div_res.remainder == '0);
  assign idx_out     = {1'b0, item_idx} >= led_count;
  assign frame_bytes = {led_count, 2'b00};

  always_comb begin
    if (!geo_ok) begin
      chk_status = slfb_pkg::STAT_BAD_GEOMETRY;
    end else if (item_len == '0) begin
      chk_status = slfb_pkg::STAT_EMPTY;
    end else if (item_len > frame_bytes) begin
      chk_status = slfb_pkg::STAT_TOO_LONG;
    end else if ((SUM_W'(item_offset) + SUM_W'(item_len)) > SUM_W'(frame_bytes)) begin
      chk_status = slfb_pkg::STAT_NO_FIT;
    end else begin
      chk_status = slfb_pkg::STAT_OK;
    end
  end

  // Store address of the current run byte and its lane in the word;
  // drop bytes that land past the end of the store
  assign byte_addr = SUM_W'(run_base) + SUM_W'(run_position);
  assign store_hit = int'(byte_addr) < MAX_LEDS * LANES;
  assign word_addr = LED_AW'(byte_addr >> LANE_W);
  assign lane      = byte_addr[LANE_W-1:0];
  assign run_last  = (SUM_W'(run_position) + SUM_W'(1)) >= SUM_W'(item_len);
  assign out_free  = !result_valid || !result_stall;

  // Replace one byte lane of the fetched word
  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      merged[k*BYTE_W +: BYTE_W] = (lane == LANE_W'(k)) ? item_byte
                                                         : ram_rdata[k*BYTE_W +: BYTE_W];
    end
  end

  assign item_stall = (state != slfb_pkg::S_IDLE);
  assign cfg_ready  = 1'b1;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= slfb_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state, divider launch and RAM port control
  always_comb begin
    state_next   = state;
    div_start    = 1'b0;
    div_dividend = led_count;
    ram_we       = 1'b0;
    ram_waddr    = word_addr;
    ram_wdata    = merged;
    ram_raddr    = word_addr;
    unique case (state)
      slfb_pkg::S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt;
        ram_wdata = '0;
        if (clr_cnt == LED_AW'(MAX_LEDS - 1)) begin
          state_next = slfb_pkg::S_IDLE;
        end
      end
      slfb_pkg::S_IDLE: begin
        if (item_valid) begin
          if (kind == slfb_pkg::KIND_WRITE && run_position != '0) begin
            state_next = slfb_pkg::S_STORE;
          end else begin
            div_start  = 1'b1;
            state_next = slfb_pkg::S_GEO;
          end
        end
      end
      slfb_pkg::S_GEO: begin
        if (div_res.done) begin
          if (item_kind == slfb_pkg::KIND_READ) begin
            if (!geo_ok || idx_out) begin
              state_next = slfb_pkg::S_RESULT;
            end else begin
              div_start    = 1'b1;
              div_dividend = DIV_W'(item_idx);
              state_next   = slfb_pkg::S_IDX;
            end
          end else if (item_len == '0) begin
            state_next = slfb_pkg::S_RESULT;
          end else begin
            state_next = slfb_pkg::S_STORE;
          end
        end
      end
      slfb_pkg::S_IDX: begin
        if (div_res.done) begin
          state_next = slfb_pkg::S_MAP;
        end
      end
      slfb_pkg::S_MAP: begin
        ram_raddr  = LED_AW'(item_idx);
        state_next = slfb_pkg::S_FETCH;
      end
      slfb_pkg::S_FETCH: begin
        state_next = slfb_pkg::S_RESULT;
      end
      slfb_pkg::S_STORE: begin
        state_next = (run_accepted && store_hit) ? slfb_pkg::S_MERGE : slfb_pkg::S_END;
      end
      slfb_pkg::S_MERGE: begin
        ram_we     = 1'b1;
        state_next = slfb_pkg::S_END;
      end
      slfb_pkg::S_END: begin
        state_next = run_last ? slfb_pkg::S_RESULT : slfb_pkg::S_IDLE;
      end
      slfb_pkg::S_RESULT: begin
        if (out_free) begin
          state_next = slfb_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = slfb_pkg::S_IDLE;
      end
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      led_count <= slfb_pkg::LED_COUNT_RESET;
      row_count <= slfb_pkg::ROW_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        slfb_pkg::CFG_LED_COUNT: led_count <= cfg_data;
        slfb_pkg::CFG_ROW_COUNT: row_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clearing sweep counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (state == slfb_pkg::S_CLEAR) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // Run state: check on the first byte, advance or close on each byte
  always_ff @(posedge clk) begin
    if (rst) begin
      run_position <= '0;
      run_base     <= '0;
      run_accepted <= 1'b0;
      run_status   <= slfb_pkg::STAT_OK;
    end else begin
      if (state == slfb_pkg::S_GEO && div_res.done && item_kind == slfb_pkg::KIND_WRITE) begin
        run_base     <= item_offset;
        run_status   <= chk_status;
        run_accepted <= (chk_status == slfb_pkg::STAT_OK);
      end
      if (state == slfb_pkg::S_END) begin
        if (run_last) begin
          run_position <= '0;
        end else begin
          run_position <= run_position + 1'b1;
        end
      end
    end
  end

  // Latch the item on transfer; build the pending result
  always_ff @(posedge clk) begin
    if (state == slfb_pkg::S_IDLE && item_valid) begin
      item_kind   <= kind;
      item_offset <= start_offset;
      item_len    <= run_length;
      item_byte   <= data_byte;
      item_idx    <= led_index;
      pend_phys   <= '0;
      pend_word   <= '0;
    end
    if (state == slfb_pkg::S_GEO && div_res.done) begin
      cols <= div_res.quotient;
      if (item_kind == slfb_pkg::KIND_READ) begin
        if (!geo_ok) begin
          pend_status <= slfb_pkg::STAT_BAD_GEOMETRY;
        end else if (idx_out) begin
          pend_status <= slfb_pkg::STAT_RANGE;
        end else begin
          pend_status <= slfb_pkg::STAT_OK;
        end
      end else begin
        pend_status <= chk_status;
      end
    end
    // Odd rows run backward along the columns
    if (state == slfb_pkg::S_MAP) begin
      prod <= PROD_W'(div_res.remainder) * PROD_W'(cols);
      if (div_res.remainder[0]) begin
        pos <= cols - 1'b1 - div_res.quotient;
      end else begin
        pos <= div_res.quotient;
      end
    end
    if (state == slfb_pkg::S_FETCH) begin
      pend_word <= ram_rdata;
      pend_phys <= slfb_pkg::PHYS_W'(prod + PROD_W'(pos));
    end
    if (state == slfb_pkg::S_END && run_last) begin
      pend_status <= run_status;
    end
  end

  // Output register: load when free, drop valid after the transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == slfb_pkg::S_RESULT && out_free) begin
      result_valid <= 1'b1;
    end else if (result_valid && !result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == slfb_pkg::S_RESULT && out_free) begin
      status         <= pend_status;
      physical_index <= pend_phys;
      pixel_word     <= pend_word;
    end
  end

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the serpentine LED frame buffer.
// Depends on slfb_pkg and serpentine_led_frame_buffer; a mirror of the frame
// and run state predicts every result, which is compared at the output.
module tb;

  localparam int MAX_LEDS       = slfb_pkg::DEFAULT_MAX_LEDS;
  localparam int STORE_BYTES    = MAX_LEDS * slfb_pkg::BYTES_PER_LED;
  localparam int SETTLE_CYCLES  = 64;
  localparam int HOLD_CYCLES    = 200;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_ITEMS    = 125;

  typedef struct packed {
    logic                          kind;
    logic [slfb_pkg::OFFSET_W-1:0] start_offset;
    logic [slfb_pkg::LEN_W-1:0]    run_length;
    logic [slfb_pkg::BYTE_W-1:0]   data_byte;
    logic [slfb_pkg::IDX_W-1:0]    led_index;
  } led_item_t;

  typedef struct packed {
    slfb_pkg::status_t             status;
    logic [slfb_pkg::PHYS_W-1:0]   physical_index;
    logic [slfb_pkg::WORD_W-1:0]   pixel_word;
  } led_reply_t;

  logic                             clk;
  logic                             rst;
  logic                             cfg_valid;
  logic                             cfg_ready;
  logic [slfb_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [slfb_pkg::CFG_DATA_W-1:0]  cfg_data;
  logic                             item_valid;
  logic                             item_stall;
  logic                             kind;
  logic [slfb_pkg::OFFSET_W-1:0]    start_offset;
  logic [slfb_pkg::LEN_W-1:0]       run_length;
  logic [slfb_pkg::BYTE_W-1:0]      data_byte;
  logic [slfb_pkg::IDX_W-1:0]       led_index;
  logic                             result_valid;
  logic                             result_stall = 1'b0;
  logic [slfb_pkg::STATUS_W-1:0]    status;
  logic [slfb_pkg::PHYS_W-1:0]      physical_index;
  logic [slfb_pkg::WORD_W-1:0]      pixel_word;

  serpentine_led_frame_buffer u_top (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .kind           (kind),
    .start_offset   (start_offset),
    .run_length     (run_length),
    .data_byte      (data_byte),
    .led_index      (led_index),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .status         (status),
    .physical_index (physical_index),
    .pixel_word     (pixel_word)
  );

  // Mirror of the frame, the run in progress and the panel registers
  logic [slfb_pkg::BYTE_W-1:0]      mirror_bytes [STORE_BYTES];
  int                               mirror_run_pos;
  int                               mirror_run_base;
  bit                               mirror_run_ok;
  slfb_pkg::status_t                mirror_run_stat;
  logic [slfb_pkg::LED_COUNT_W-1:0] mirror_leds;
  logic [slfb_pkg::ROW_COUNT_W-1:0] mirror_rows;

  led_reply_t replies_due [$];
  led_reply_t rx_want;

  int errors          = 0;
  int items_sent      = 0;
  int reads_sent      = 0;
  int replies_checked = 0;
  int panel_settings  = 0;
  int rx_wait         = 0;
  int rx_roll;
  int idle_cycles;
  bit idle_on         = 1'b1;
  bit hold_request    = 1'b0;
  logic hold_active   = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Advance the mirror by one transfer; returns 1 when the item yields a result
  function automatic bit frame_mirror_step(input led_item_t it, output led_reply_t rep);
    int leds, rows, len, frame_bytes, columns, col, row, addr, k;
    bit geo_ok;
    leds = int'(mirror_leds);
    rows = int'(mirror_rows);
    len = int'(it.run_length);
    frame_bytes = leds * slfb_pkg::BYTES_PER_LED;
    rep = '0;
    geo_ok = 1'b0;
    if (rows != 0 && leds <= MAX_LEDS) geo_ok = (leds % rows) == 0;

    if (it.kind == slfb_pkg::KIND_READ) begin
      if (!geo_ok) begin
        rep.status = slfb_pkg::STAT_BAD_GEOMETRY;
      end else if (int'(it.led_index) >= leds) begin
        rep.status = slfb_pkg::STAT_RANGE;
      end else begin
        addr = int'(it.led_index) * slfb_pkg::BYTES_PER_LED;
        for (k = 0; k < slfb_pkg::BYTES_PER_LED; k++)
          rep.pixel_word[8*k +: 8] = mirror_bytes[addr + k];
        columns = leds / rows;
        col = int'(it.led_index) / rows;
        row = int'(it.led_index) % rows;
        rep.physical_index = slfb_pkg::PHYS_W'(row * columns +
                             ((row % 2 == 1) ? columns - 1 - col : col));
        rep.status = slfb_pkg::STAT_OK;
      end
      return 1'b1;
    end

    // First byte of a run: latch the base and judge the whole run
    if (mirror_run_pos == 0) begin
      mirror_run_base = int'(it.start_offset);
      if (!geo_ok) mirror_run_stat = slfb_pkg::STAT_BAD_GEOMETRY;
      else if (len == 0) mirror_run_stat = slfb_pkg::STAT_EMPTY;
      else if (len > frame_bytes) mirror_run_stat = slfb_pkg::STAT_TOO_LONG;
      else if (mirror_run_base + len > frame_bytes) mirror_run_stat = slfb_pkg::STAT_NO_FIT;
      else mirror_run_stat = slfb_pkg::STAT_OK;
      mirror_run_ok = (mirror_run_stat == slfb_pkg::STAT_OK);
      if (len == 0) begin
        rep.status = mirror_run_stat;
        return 1'b1;
      end
    end

    addr = mirror_run_base + mirror_run_pos;
    if (mirror_run_ok && addr < STORE_BYTES) mirror_bytes[addr] = it.data_byte;

    // The current item's length decides where the run ends
    if (mirror_run_pos + 1 >= len) begin
      mirror_run_pos = 0;
      rep.status = mirror_run_stat;
      return 1'b1;
    end
    mirror_run_pos = (mirror_run_pos + 1) % 2048;
    return 1'b0;
  endfunction

  // Offer one item, hold it until the transfer, then predict its result
  task automatic send_item(input led_item_t it);
    int gap;
    led_reply_t rep;
    gap = 0;
    if (idle_on) begin
      gap = $urandom_range(0, 99);
      gap = (gap < 60) ? 0 : (gap < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    end
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid   <= 1'b1;
    kind         <= it.kind;
    start_offset <= it.start_offset;
    run_length   <= it.run_length;
    data_byte    <= it.data_byte;
    led_index    <= it.led_index;
    do @(posedge clk); while (item_stall);
    if (frame_mirror_step(it, rep)) replies_due.push_back(rep);
    items_sent++;
    if (it.kind == slfb_pkg::KIND_READ) reads_sent++;
  endtask

  task automatic send_write(input int offset, input int len, input int value);
    led_item_t it;
    it.kind         = slfb_pkg::KIND_WRITE;
    it.start_offset = slfb_pkg::OFFSET_W'(offset);
    it.run_length   = slfb_pkg::LEN_W'(len);
    it.data_byte    = slfb_pkg::BYTE_W'(value);
    it.led_index    = slfb_pkg::IDX_W'($urandom);
    send_item(it);
  endtask

  task automatic send_read(input int idx);
    led_item_t it;
    it.kind         = slfb_pkg::KIND_READ;
    it.start_offset = slfb_pkg::OFFSET_W'($urandom);
    it.run_length   = slfb_pkg::LEN_W'($urandom_range(0, 1024));
    it.data_byte    = slfb_pkg::BYTE_W'($urandom);
    it.led_index    = slfb_pkg::IDX_W'(idx);
    send_item(it);
  endtask

  // Drop the item valid and wait for every predicted result
  task automatic drain_replies();
    item_valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
  endtask

  // Write one register with the block idle
  task automatic set_register(input logic [slfb_pkg::CFG_INDEX_W-1:0] idx, input int value);
    drain_replies();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= slfb_pkg::CFG_DATA_W'(value);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      slfb_pkg::CFG_LED_COUNT: mirror_leds = slfb_pkg::LED_COUNT_W'(value);
      slfb_pkg::CFG_ROW_COUNT: mirror_rows = slfb_pkg::ROW_COUNT_W'(value);
      default: ;
    endcase
  endtask

  task automatic set_panel(input int leds, input int rows);
    set_register(slfb_pkg::CFG_LED_COUNT, leds);
    set_register(slfb_pkg::CFG_ROW_COUNT, rows);
    panel_settings++;
  endtask

  task automatic random_read();
    int leds;
    leds = int'(mirror_leds);
    if (leds > 0 && $urandom_range(0, 99) < 85) send_read($urandom_range(0, leds - 1));
    else send_read($urandom_range(0, 255));
  endtask

  // Well-formed run: constant length, offset taken from the first byte, random bytes, stray reads
  task automatic random_run();
    int frame_bytes, len, offset, roll, cap, i;
    frame_bytes = int'(mirror_leds) * slfb_pkg::BYTES_PER_LED;
    roll = $urandom_range(0, 99);
    if (frame_bytes == 0) begin
      len = $urandom_range(1, 8);
      offset = $urandom_range(0, 1023);
    end else begin
      cap = (roll < 80) ? 12 : (roll < 95) ? 64 : 96;
      if (cap > frame_bytes) cap = frame_bytes;
      len = (roll >= 95 && frame_bytes <= 96) ? frame_bytes : $urandom_range(1, cap);
      offset = $urandom_range(0, frame_bytes - len);
    end
    for (i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < 8) random_read();
      send_write((i == 0 || $urandom_range(0, 1) == 0) ? offset : $urandom_range(0, 1023),
                 len, $urandom);
    end
  endtask

  // Broken run: arbitrary header and up to two more bytes of arbitrary length
  task automatic random_broken_run();
    send_write($urandom_range(0, 1023), $urandom_range(0, 1024), $urandom);
    repeat ($urandom_range(0, 2)) send_write($urandom_range(0, 1023), $urandom_range(0, 1024),
                                             $urandom);
  endtask

  task automatic random_mix(input int count);
    int stop, roll;
    stop = items_sent + count;
    while (items_sent < stop) begin
      roll = $urandom_range(0, 99);
      if (roll < 55) random_run();
      else if (roll < 80) random_read();
      else if (roll < 90) random_broken_run();
      else send_write($urandom_range(0, 1023), 0, $urandom);
      // close any run left open, so the next run starts clean
      while (mirror_run_pos != 0)
        send_write($urandom_range(0, 1023), $urandom_range(0, mirror_run_pos + 1), $urandom);
    end
  endtask

  task automatic test_after_reset();
    send_read(0);
    send_read(255);
  endtask

  task automatic test_write_runs();
    send_write(0, 4, 8'hFF);
    send_write(0, 4, 8'h00);
    send_write(0, 4, 8'hA5);
    send_write(0, 4, 8'h5A);
    send_read(0);
    send_write(1020, 4, 8'h01);
    send_write(1020, 4, 8'h80);
    send_write(1020, 4, 8'h7F);
    send_write(1020, 4, 8'hFE);
    send_read(255);
    // full-frame header, cut short by the length on the next byte
    send_write(0, 1024, 8'h3C);
    send_write(1023, 2, 8'hC3);
    send_read(0);
  endtask

  task automatic test_run_errors();
    send_write(1023, 2, 8'h11);
    send_write(0, 2, 8'h22);
    send_write(1023, 0, 8'h33);
    set_panel(64, 8);
    send_write(0, 257, 8'h44);
    send_write(0, 1, 8'h55);
  endtask

  task automatic test_geometry();
    set_panel(16, 0);
    send_read(0);
    send_write(0, 0, 8'h00);
    set_panel(10, 3);
    send_read(1);
    set_panel(0, 1);
    send_read(0);
    send_write(0, 1, 8'h99);
  endtask

  task automatic test_serpentine();
    set_panel(12, 3);
    send_read(4);
    send_read(11);
    set_panel(256, 256);
    send_read(255);
    set_panel(16, 4);
    send_read(16);
  endtask

  task automatic test_random_traffic();
    int p;
    for (p = 0; p < 12; p++) begin
      case (p)
        0:  set_panel(256, 1);
        1:  set_panel(256, 256);
        2:  set_panel(256, 16);
        3:  set_panel(0, 1);
        4:  set_panel(1, 1);
        5:  set_panel(12, 3);
        6:  set_panel(100, 10);
        7:  set_panel(64, 8);
        8:  set_panel(10, 3);
        9:  set_panel(16, 0);
        10: set_panel(255, 5);
        default: set_panel(256, 2);
      endcase
      random_mix(PHASE_ITEMS);
    end
  endtask

  // Hold the output off long enough that the block stalls its input
  task automatic test_backpressure();
    set_panel(64, 4);
    idle_on = 1'b0;
    hold_request = 1'b1;
    random_mix(40);
    drain_replies();
    idle_on = 1'b1;
  endtask

  task automatic test_back_to_back();
    idle_on = 1'b0;
    random_mix(150);
    drain_replies();
    idle_on = 1'b1;
  endtask

  // Long receiver hold-off, counted here
  initial begin
    wait (hold_request);
    @(posedge clk);
    hold_active <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_active <= 1'b0;
  end

  // Check each result transfer and choose the stall for the next cycle
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      replies_checked++;
      if (replies_due.size() == 0) begin
        errors++;
        $error("result with nothing expected: status %0d physical_index %0d pixel_word %08h",
               status, physical_index, pixel_word);
      end else begin
        rx_want = replies_due.pop_front();
        if (status !== rx_want.status) begin
          errors++;
          $error("status: expected %0d, actual %0d", rx_want.status, status);
        end
        if (physical_index !== rx_want.physical_index) begin
          errors++;
          $error("physical_index: expected %0d, actual %0d",
                 rx_want.physical_index, physical_index);
        end
        if (pixel_word !== rx_want.pixel_word) begin
          errors++;
          $error("pixel_word: expected %08h, actual %08h", rx_want.pixel_word, pixel_word);
        end
      end
    end

    if (hold_active) begin
      result_stall <= 1'b1;
    end else if (idle_on && rx_wait > 0) begin
      result_stall <= 1'b1;
      rx_wait--;
    end else begin
      result_stall <= 1'b0;
      rx_roll = $urandom_range(0, 99);
      if (idle_on && rx_roll >= 65)
        rx_wait = (rx_roll < 95) ? $urandom_range(1, 4) : $urandom_range(20, 60);
    end
  end

  // End the run when no transfer of any kind happens for too long
  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
          (cfg_valid && cfg_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("FAIL serpentine_led_frame_buffer");
    $finish;
  end

  initial begin
    rst          = 1'b1;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    item_valid   = 1'b0;
    kind         = slfb_pkg::KIND_WRITE;
    start_offset = '0;
    run_length   = '0;
    data_byte    = '0;
    led_index    = '0;
    for (int a = 0; a < STORE_BYTES; a++) mirror_bytes[a] = '0;
    mirror_run_pos  = 0;
    mirror_run_base = 0;
    mirror_run_ok   = 1'b0;
    mirror_run_stat = slfb_pkg::STAT_OK;
    mirror_leds     = slfb_pkg::LED_COUNT_RESET;
    mirror_rows     = slfb_pkg::ROW_COUNT_RESET;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_after_reset();
    test_write_runs();
    test_run_errors();
    test_geometry();
    test_serpentine();
    test_random_traffic();
    test_backpressure();
    test_back_to_back();

    drain_replies();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d items (%0d reads) across %0d panel settings, with idle gaps,",
             items_sent, reads_sent, panel_settings);
    $display("a long output hold-off and back-to-back traffic; %0d results compared.",
             replies_checked);
    if (errors == 0) begin
      $display("PASS serpentine_led_frame_buffer");
    end else begin
      $display("FAIL serpentine_led_frame_buffer");
    end
    $finish;
  end

endmodule
